>>> rtl/core/flam_pkg.sv
// ----------------------------------------------------------------------------
// flam_pkg
// Shared types and constants for the frame luma average meter.
// ----------------------------------------------------------------------------
`default_nettype none

package flam_pkg;

  localparam int MAX_PIXELS  = 65536;
  localparam int NUM_SENSORS = 8;

  localparam int COLOR_W  = 8;
  localparam int SENSOR_W = 3;
  localparam int MV_W     = 13;
  localparam int LUMA_W   = 24;
  localparam int CNT_W    = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W    = LUMA_W + CNT_W - 1;

  localparam logic [15:0] W_RED   = 16'd19589;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  // 2100 / 130 reduced to 210 / 13
  localparam logic [7:0]  SPAN_NUM  = 8'd210;
  localparam logic [3:0]  SPAN_DEN  = 4'd13;
  localparam int          FRAC_BITS = 16;
  localparam logic [MV_W-1:0] BASE_MV = 13'd1200;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic CFG_MIN_IDX = 1'b0;
  localparam logic CFG_MAX_IDX = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [SENSOR_W-1:0] idx;
    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    count;
  } cmd_t;

  typedef struct packed {
    logic [MV_W-1:0] min_mv;
    logic [MV_W-1:0] max_mv;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/flam_front.sv
// ----------------------------------------------------------------------------
// flam_front
// Accepts input transactions, accumulates pixel luma and pixel count, and
// queues a command at the end of each frame and for each read.
// ----------------------------------------------------------------------------
`default_nettype none

module flam_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_operation,
  input  wire logic [flam_pkg::COLOR_W-1:0]   in_red,
  input  wire logic [flam_pkg::COLOR_W-1:0]   in_green,
  input  wire logic [flam_pkg::COLOR_W-1:0]   in_blue,
  input  wire logic                           in_last_pixel,
  input  wire logic [flam_pkg::SENSOR_W-1:0]  in_sensor_index,
  input  wire logic                           q_ready,
  output logic                                q_push,
  output flam_pkg::cmd_t                      q_cmd
);

  logic [flam_pkg::SUM_W-1:0]  sum_r, sum_nxt, sum_add;
  logic [flam_pkg::CNT_W-1:0]  count_r, count_nxt, count_add;
  logic [flam_pkg::LUMA_W:0]   luma_full;
  logic [flam_pkg::LUMA_W-1:0] luma;
  logic                        accept;
  logic                        room;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  assign luma_full = (flam_pkg::LUMA_W+1)'(in_red)
                     * (flam_pkg::LUMA_W+1)'(flam_pkg::W_RED)
                   + (flam_pkg::LUMA_W+1)'(in_green)
                     * (flam_pkg::LUMA_W+1)'(flam_pkg::W_GREEN)
                   + (flam_pkg::LUMA_W+1)'(in_blue)
                     * (flam_pkg::LUMA_W+1)'(flam_pkg::W_BLUE);
  assign luma = luma_full[flam_pkg::LUMA_W-1:0];

  assign room = (32'(count_r) < flam_pkg::MAX_PIXELS);

  always_comb begin
    sum_add   = sum_r;
    count_add = count_r;
    if (room) begin
      sum_add   = sum_r + flam_pkg::SUM_W'(luma);
      count_add = count_r + flam_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    q_push    = 1'b0;
    q_cmd     = '{kind: flam_pkg::KIND_READ, idx: in_sensor_index,
                  sum: sum_add, count: count_add};
    if (accept) begin
      if (in_operation == flam_pkg::OP_READ) begin
        q_push = 1'b1;
      end else begin
        q_cmd.kind = flam_pkg::KIND_FRAME;
        if (in_last_pixel) begin
          q_push    = 1'b1;
          sum_nxt   = '0;
          count_nxt = '0;
        end else begin
          sum_nxt   = sum_add;
          count_nxt = count_add;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/flam_queue.sv
// ----------------------------------------------------------------------------
// flam_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module flam_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  flam_pkg::cmd_t       push_cmd,
  output logic                 push_ready,
  input  wire logic            pop,
  output logic                 pop_valid,
  output flam_pkg::cmd_t       pop_cmd
);

  flam_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/flam_back.sv
// ----------------------------------------------------------------------------
// flam_back
// Executes queued commands: computes the frame voltage with a radix-2
// divider, checks the bounds, updates the readings and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module flam_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  flam_pkg::cfg_t                      cfg,
  input  wire logic                           q_valid,
  input  flam_pkg::cmd_t                      q_cmd,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_result_kind,
  output logic [flam_pkg::SENSOR_W-1:0]       out_sensor_id,
  output logic [flam_pkg::MV_W-1:0]           out_voltage_mv,
  output logic                                out_accepted,
  output logic [flam_pkg::MV_W-1:0]           out_stored_mv
);

  localparam int NUM_W  = flam_pkg::SUM_W + 8 - flam_pkg::FRAC_BITS;
  localparam int PROD_W = flam_pkg::SUM_W + 8;
  localparam int DEN_W  = flam_pkg::CNT_W + 4;
  localparam int QUO_W  = flam_pkg::MV_W;
  localparam int STEP_W = $clog2(QUO_W);
  localparam int TRY_W  = NUM_W + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  flam_pkg::cmd_t             cmd_r;
  logic [NUM_W-1:0]           rem_r, rem_nxt;
  logic [DEN_W-1:0]           den_r, den_nxt;
  logic [QUO_W-1:0]           quo_r, quo_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [flam_pkg::MV_W-1:0]  volt_r, volt_nxt;
  logic                       ok_r, ok_nxt;
  logic [flam_pkg::MV_W-1:0]  readings_r [flam_pkg::NUM_SENSORS];
  logic                       out_valid_r;
  logic                       out_kind_r;
  logic [flam_pkg::SENSOR_W-1:0] out_id_r;
  logic [flam_pkg::MV_W-1:0]  out_volt_r, out_stored_r;
  logic                       out_ok_r;

  logic [PROD_W-1:0]          prod;
  logic [TRY_W-1:0]           trial;
  logic                       quo_bit;
  logic                       in_range;
  logic [flam_pkg::MV_W-1:0]  stored_cur;
  logic                       load;

  assign in_range   = (32'(cmd_r.idx) < flam_pkg::NUM_SENSORS);
  assign stored_cur = in_range ? readings_r[cmd_r.idx] : '0;
  assign load       = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign q_pop      = (state_r == ST_IDLE) && q_valid;

  assign prod    = PROD_W'(cmd_r.sum) * PROD_W'(flam_pkg::SPAN_NUM);
  assign trial   = {2'b00, rem_r} - (TRY_W'(den_r) << step_r);
  assign quo_bit = ~trial[TRY_W-1];

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    volt_nxt  = volt_r;
    ok_nxt    = ok_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_cmd.kind == flam_pkg::KIND_READ) ? ST_OUT : ST_MUL;
          volt_nxt  = '0;
          ok_nxt    = 1'b0;
        end
      end
      ST_MUL: begin
        rem_nxt   = prod[PROD_W-1:flam_pkg::FRAC_BITS];
        den_nxt   = DEN_W'(cmd_r.count) * DEN_W'(flam_pkg::SPAN_DEN);
        quo_nxt   = '0;
        step_nxt  = STEP_W'(QUO_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        quo_nxt = {quo_r[QUO_W-2:0], quo_bit};
        if (quo_bit) begin
          rem_nxt = trial[NUM_W-1:0];
        end
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        volt_nxt  = flam_pkg::BASE_MV + quo_r;
        ok_nxt    = (volt_nxt >= cfg.min_mv) && (volt_nxt <= cfg.max_mv) && in_range;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    volt_r <= volt_nxt;
    ok_r   <= ok_nxt;
    if (load) begin
      out_kind_r   <= cmd_r.kind;
      out_id_r     <= cmd_r.idx;
      out_volt_r   <= volt_r;
      out_ok_r     <= ok_r;
      out_stored_r <= ok_r ? volt_r : stored_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < flam_pkg::NUM_SENSORS; i++) begin
        readings_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load && ok_r) begin
        readings_r[cmd_r.idx] <= volt_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_sensor_id   = out_id_r;
  assign out_voltage_mv  = out_volt_r;
  assign out_accepted    = out_ok_r;
  assign out_stored_mv   = out_stored_r;

endmodule

`default_nettype wire

>>> rtl/core/frame_luma_average_meter_core.sv
// ----------------------------------------------------------------------------
// frame_luma_average_meter_core
// Accumulates BT.601 luma over a frame and converts the mean to a voltage
// reading per sensor, with bounds check and a per-sensor readings store.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid/in_ready     operation, rgb, last, sensor
//   out_     output     out_valid/out_ready   kind, sensor, voltage, accepted, stored
//   cfg_     input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Input is taken one per cycle while the queue has room.
// The back end runs a frame end through multiply, radix-2 divide, finish and
// output, a read straight to output. A two-entry queue decouples the two ends.
// Synchronous reset clears the accumulator, readings and control state.
// A stalled output holds its result; the queue takes two more commands, then
// input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_luma_average_meter_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_operation,
  input  wire logic [flam_pkg::COLOR_W-1:0]   in_red,
  input  wire logic [flam_pkg::COLOR_W-1:0]   in_green,
  input  wire logic [flam_pkg::COLOR_W-1:0]   in_blue,
  input  wire logic                           in_last_pixel,
  input  wire logic [flam_pkg::SENSOR_W-1:0]  in_sensor_index,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_result_kind,
  output logic [flam_pkg::SENSOR_W-1:0]       out_sensor_id,
  output logic [flam_pkg::MV_W-1:0]           out_voltage_mv,
  output logic                                out_accepted,
  output logic [flam_pkg::MV_W-1:0]           out_stored_mv,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_index,
  input  wire logic [flam_pkg::MV_W-1:0]      cfg_data
);

  flam_pkg::cfg_t cfg_r;
  flam_pkg::cmd_t push_cmd, pop_cmd;
  logic           push, push_ready, pop, pop_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_mv <= 13'd1000;
      cfg_r.max_mv <= 13'd3500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        flam_pkg::CFG_MIN_IDX: cfg_r.min_mv <= cfg_data;
        flam_pkg::CFG_MAX_IDX: cfg_r.max_mv <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  flam_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_last_pixel   (in_last_pixel),
    .in_sensor_index (in_sensor_index),
    .q_ready         (push_ready),
    .q_push          (push),
    .q_cmd           (push_cmd)
  );

  flam_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd)
  );

  flam_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (pop_valid),
    .q_cmd           (pop_cmd),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_sensor_id   (out_sensor_id),
    .out_voltage_mv  (out_voltage_mv),
    .out_accepted    (out_accepted),
    .out_stored_mv   (out_stored_mv)
  );

  a_frame_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == flam_pkg::KIND_FRAME)
    |-> out_voltage_mv >= flam_pkg::BASE_MV)
    else $error("frame voltage below base");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == flam_pkg::KIND_READ)
    |-> (out_voltage_mv == '0) && !out_accepted)
    else $error("read reply carries frame fields");

  a_accept_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted
    |-> (out_stored_mv == out_voltage_mv) && (out_voltage_mv >= cfg_r.min_mv)
        && (out_voltage_mv <= cfg_r.max_mv))
    else $error("accepted voltage not stored or out of bounds");

endmodule

`default_nettype wire
